// File: rtl/ssfm_pkg.sv
// Shared types and constants for the substring first-match search block.
`default_nettype none
package ssfm_pkg;

  localparam int NEEDLE_MAX = 32;
  localparam int CODE_W     = 21;
  localparam int LEN_W      = $clog2(NEEDLE_MAX + 1);
  localparam int COUNT_W    = 32;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START  = 2'd0,
    FUNC_NEEDLE = 2'd1,
    FUNC_HAY    = 2'd2,
    FUNC_END    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/ssfm_in_if.sv
// Request channel carrying search commands and character codes.
`default_nettype none
interface ssfm_in_if;
  logic                         valid;
  logic                         ready;
  logic [ssfm_pkg::FUNC_W-1:0]  func;
  logic [ssfm_pkg::CODE_W-1:0]  code;

  modport source (output valid, output func, output code, input ready);
  modport sink   (input valid, input func, input code, output ready);
endinterface
`default_nettype wire

// File: rtl/ssfm_out_if.sv
// Result channel carrying the search status and match position.
`default_nettype none
interface ssfm_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssfm_pkg::STATUS_W-1:0] status;
  logic [ssfm_pkg::COUNT_W-1:0]  position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface
`default_nettype wire

// File: rtl/substring_first_match.sv
// Top level of the substring first-match search with its chain of match cells.
//
// Requests arrive on req_i: a start command, then needle codes one per request,
// then haystack codes one per request, then an end command. Each search gives
// at most one result on res_o: found with the start position of the first
// match, not found, or needle too long. Results wait in one output register.
// One request is taken in every cycle; the result of a request appears on
// res_o in the cycle after it is accepted. All needle positions are compared
// at once by the cell row, and each partial-match bit moves one cell on per
// haystack code, so the rate is set by the single compare in each cell.
// While a result waits and the receiver holds ready low, req_i stalls.
// Reset clears the search state as an empty-needle search; stored needle codes
// keep no reset value and only the loaded ones can affect a result.
`default_nettype none
module substring_first_match (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssfm_in_if.sink           req_i,
  ssfm_out_if.source        res_o
);

  localparam int NMAX = ssfm_pkg::NEEDLE_MAX;
  localparam int LW   = ssfm_pkg::LEN_W;
  localparam int CW   = ssfm_pkg::COUNT_W;

  logic [LW-1:0]            len_q, len_d;
  logic [CW-1:0]            count_q, count_d, count_inc;
  logic                     answered_q, answered_d;
  logic                     overflow_q, overflow_d;
  logic                     out_valid_q, out_valid_d;
  logic [ssfm_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [CW-1:0]            out_pos_q, out_pos_d;

  logic                     accept;
  logic                     emit;
  logic                     load_en;
  logic                     shift_en;
  logic                     clear_en;
  logic                     found;
  logic [NMAX-1:0]          match_q;
  logic [NMAX-1:0]          match_next;
  logic [NMAX-1:0]          last_mask;
  ssfm_pkg::cell_ctrl_t     cell_ctrl [NMAX];

  assign req_i.ready = !out_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    for (int k = 0; k < NMAX; k++) begin
      last_mask[k] = (len_q == LW'(k + 1));
    end
  end

  assign found     = |(match_next & last_mask);
  assign count_inc = (count_q != '1) ? (count_q + CW'(1)) : count_q;

  always_comb begin
    len_d        = len_q;
    count_d      = count_q;
    answered_d   = answered_q;
    overflow_d   = overflow_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    load_en      = 1'b0;
    shift_en     = 1'b0;
    clear_en     = 1'b0;
    emit         = 1'b0;
    if (accept) begin
      case (req_i.func)
        ssfm_pkg::FUNC_START: begin
          clear_en   = 1'b1;
          len_d      = '0;
          count_d    = '0;
          answered_d = 1'b0;
          overflow_d = 1'b0;
        end
        ssfm_pkg::FUNC_NEEDLE: begin
          if (!answered_q && (count_q == '0)) begin
            if (len_q < LW'(NMAX)) begin
              load_en = 1'b1;
              len_d   = len_q + LW'(1);
            end else begin
              overflow_d = 1'b1;
            end
          end
        end
        ssfm_pkg::FUNC_HAY, ssfm_pkg::FUNC_END: begin
          if (!answered_q) begin
            if (overflow_q) begin
              emit         = 1'b1;
              out_status_d = ssfm_pkg::STATUS_TOO_LONG;
              out_pos_d    = '0;
            end else if (len_q == '0) begin
              emit         = 1'b1;
              out_status_d = ssfm_pkg::STATUS_FOUND;
              out_pos_d    = '0;
            end else if (req_i.func == ssfm_pkg::FUNC_END) begin
              emit         = 1'b1;
              out_status_d = ssfm_pkg::STATUS_NOT_FOUND;
              out_pos_d    = '0;
            end else begin
              shift_en = 1'b1;
              count_d  = count_inc;
              if (found) begin
                emit         = 1'b1;
                out_status_d = ssfm_pkg::STATUS_FOUND;
                out_pos_d    = count_inc - CW'(len_q);
              end
            end
          end
        end
        default: begin
          clear_en = 1'b0;
        end
      endcase
      if (emit) begin
        answered_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      count_q     <= '0;
      answered_q  <= 1'b0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      count_q     <= count_d;
      answered_q  <= answered_d;
      overflow_q  <= overflow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
  end

  for (genvar k = 0; k < NMAX; k++) begin : g_cell
    logic prev_match;
    if (k == 0) begin : g_first
      assign prev_match = 1'b1;
    end else begin : g_rest
      assign prev_match = match_q[k-1];
    end

    always_comb begin
      cell_ctrl[k].load  = load_en && (len_q == LW'(k));
      cell_ctrl[k].shift = shift_en;
      cell_ctrl[k].clear = clear_en;
    end

    ssfm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl[k]),
      .code_i       (req_i.code),
      .prev_match_i (prev_match),
      .match_o      (match_q[k]),
      .match_next_o (match_next[k])
    );
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.status   = out_status_q;
  assign res_o.position = out_pos_q;

`ifndef NO_ASSERTIONS
  a_single_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !answered_q)
    else $error("second result given within one search");

  a_answer_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (answered_q && !(accept && (req_i.func == ssfm_pkg::FUNC_START))) |=> answered_q)
    else $error("answered flag dropped without a start request");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |-> (len_q == LW'(NMAX)))
    else $error("needle overflow flagged before the store is full");
`endif

endmodule
`default_nettype wire

// File: rtl/ssfm_cell.sv
// One search cell: a stored needle code and the partial-match bit ending here.
`default_nettype none
module ssfm_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssfm_pkg::cell_ctrl_t        ctrl_i,
  input  logic [ssfm_pkg::CODE_W-1:0] code_i,
  input  logic                        prev_match_i,
  output logic                        match_o,
  output logic                        match_next_o
);

  logic [ssfm_pkg::CODE_W-1:0] needle_q;
  logic                        match_q;
  logic                        match_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      needle_q <= code_i;
    end
  end

  assign match_next_o = prev_match_i && (code_i == needle_q);

  always_comb begin
    match_d = match_q;
    if (ctrl_i.clear) begin
      match_d = 1'b0;
    end else if (ctrl_i.shift) begin
      match_d = match_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule
`default_nettype wire

// File: tb/tb_substring_first_match.sv
// Testbench for the substring first-match search block, checked against a behavioral predictor.
`default_nettype none
module tb_substring_first_match;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CODE_MAX    = 1114111;
  localparam int RAND_ITEMS  = 1900;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    ssfm_pkg::func_e             func;
    logic [ssfm_pkg::CODE_W-1:0] code;
    bit                          drain;
  } request_t;

  typedef struct {
    ssfm_pkg::status_e            status;
    logic [ssfm_pkg::COUNT_W-1:0] position;
  } answer_t;

  logic clk;
  logic rst_n;

  ssfm_in_if  req_if ();
  ssfm_out_if res_if ();

  substring_first_match DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  request_t request_q[$];
  answer_t  expected_answers[$];
  int       total_items;
  int       accepted_count;
  int       answers_seen;
  int       cycle_count;
  int       mismatch_count;
  bit       req_fire;

  logic [ssfm_pkg::CODE_W-1:0]  needle_codes[ssfm_pkg::NEEDLE_MAX];
  logic [ssfm_pkg::CODE_W-1:0]  window[ssfm_pkg::NEEDLE_MAX];
  int                           needle_len;
  int                           window_fill;
  logic [ssfm_pkg::COUNT_W-1:0] hay_count;
  bit                           answered;
  bit                           needle_over;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Updates the search state for one request and returns whether it answers.
  function automatic bit predict_answer(input ssfm_pkg::func_e f,
                                        input logic [ssfm_pkg::CODE_W-1:0] c,
                                        output answer_t ans);
    int k;
    bit hit;
    ans.status   = ssfm_pkg::STATUS_FOUND;
    ans.position = '0;
    case (f)
      ssfm_pkg::FUNC_START: begin
        needle_len  = 0;
        for (k = 0; k < ssfm_pkg::NEEDLE_MAX; k++) window[k] = '0;
        window_fill = 0;
        hay_count   = '0;
        answered    = 1'b0;
        needle_over = 1'b0;
        return 1'b0;
      end
      ssfm_pkg::FUNC_NEEDLE: begin
        if (answered || hay_count != '0) return 1'b0;
        if (needle_len < ssfm_pkg::NEEDLE_MAX) begin
          needle_codes[needle_len] = c;
          needle_len++;
        end else begin
          needle_over = 1'b1;
        end
        return 1'b0;
      end
      default: ;
    endcase
    if (answered) return 1'b0;
    if (needle_over) begin
      ans.status = ssfm_pkg::STATUS_TOO_LONG;
      answered   = 1'b1;
      return 1'b1;
    end
    if (needle_len == 0) begin
      answered = 1'b1;
      return 1'b1;
    end
    if (f == ssfm_pkg::FUNC_END) begin
      ans.status = ssfm_pkg::STATUS_NOT_FOUND;
      answered   = 1'b1;
      return 1'b1;
    end
    for (k = ssfm_pkg::NEEDLE_MAX - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = c;
    if (window_fill < ssfm_pkg::NEEDLE_MAX) window_fill++;
    if (hay_count != '1) hay_count++;
    if (window_fill < needle_len) return 1'b0;
    hit = 1'b1;
    for (k = 0; k < needle_len; k++) begin
      if (window[needle_len-1-k] != needle_codes[k]) hit = 1'b0;
    end
    if (!hit) return 1'b0;
    answered     = 1'b1;
    ans.position = hay_count - ssfm_pkg::COUNT_W'(needle_len);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_request(input ssfm_pkg::func_e f,
                               input logic [ssfm_pkg::CODE_W-1:0] c, input bit drain);
    request_t r;
    r.func  = f;
    r.code  = c;
    r.drain = drain;
    request_q.push_back(r);
    total_items++;
  endtask

  task automatic queue_search();
    logic [ssfm_pkg::CODE_W-1:0] alpha[4];
    logic [ssfm_pkg::CODE_W-1:0] pattern[40];
    logic [ssfm_pkg::CODE_W-1:0] c;
    int nsym, nlen, hlen, plant, r, k;
    nsym = $urandom_range(1, 4);
    for (k = 0; k < 4; k++) alpha[k] = ssfm_pkg::CODE_W'($urandom_range(0, CODE_MAX));
    r = $urandom_range(0, 99);
    if (r < 5) nlen = 0;
    else if (r < 72) nlen = $urandom_range(1, 4);
    else if (r < 87) nlen = $urandom_range(5, 12);
    else if (r < 96) nlen = $urandom_range(0, 1) ? ssfm_pkg::NEEDLE_MAX : $urandom_range(13, 31);
    else nlen = $urandom_range(ssfm_pkg::NEEDLE_MAX + 1, ssfm_pkg::NEEDLE_MAX + 4);
    for (k = 0; k < nlen; k++) pattern[k] = alpha[$urandom_range(0, nsym - 1)];
    hlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, nlen + 8);
    plant = ($urandom_range(0, 1) == 1 && hlen >= nlen) ? $urandom_range(0, hlen - nlen) : -1;
    queue_request(ssfm_pkg::FUNC_START, ssfm_pkg::CODE_W'($urandom_range(0, CODE_MAX)),
                  $urandom_range(0, 29) == 0);
    for (k = 0; k < nlen; k++) queue_request(ssfm_pkg::FUNC_NEEDLE, pattern[k], 1'b0);
    for (k = 0; k < hlen; k++) begin
      if (plant >= 0 && k >= plant && k < plant + nlen) c = pattern[k-plant];
      else c = alpha[$urandom_range(0, nsym - 1)];
      queue_request(ssfm_pkg::FUNC_HAY, c, 1'b0);
      if ($urandom_range(0, 39) == 0) begin
        queue_request(ssfm_pkg::FUNC_NEEDLE,
                      ssfm_pkg::CODE_W'($urandom_range(0, CODE_MAX)), 1'b0);
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      queue_request(ssfm_pkg::FUNC_END, ssfm_pkg::CODE_W'($urandom_range(0, CODE_MAX)), 1'b0);
    end
  endtask

  task automatic queue_noise();
    int k;
    for (k = $urandom_range(1, 6); k > 0; k--) begin
      queue_request(ssfm_pkg::func_e'($urandom_range(0, 3)),
                    ssfm_pkg::CODE_W'($urandom_range(0, CODE_MAX)), 1'b0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver.
  int  send_gap;
  bit  send_calm;
  request_t cur_req;

  always @(negedge clk) begin
    if (rst_n && !(req_if.valid && !req_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].drain && expected_answers.size() != 0)) begin
        cur_req = request_q.pop_front();
        req_if.valid <= 1'b1;
        req_if.func  <= cur_req.func;
        req_if.code  <= cur_req.code;
        send_gap = send_calm ? 0 : pick_gap();
        if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and occasional long hold-offs.
  int sink_gap;
  int hold_left;
  int hold_mark = 12;
  bit sink_calm;

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left == 0 && answers_seen >= hold_mark) begin
        hold_left = HOLD_CYCLES;
        hold_mark += 90;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (!sink_calm && $urandom_range(0, 3) == 0) sink_gap = pick_gap();
        if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
      end
    end
  end

  // Monitor: checks results, then predicts from accepted requests.
  answer_t want;
  answer_t got_ans;

  always @(posedge clk) begin
    req_fire = 1'b0;
    if (rst_n) begin
      cycle_count++;
      if (res_if.valid && res_if.ready) begin
        answers_seen++;
        if (expected_answers.size() == 0) begin
          report_mismatch("result with none pending, position", res_if.position, '0);
        end else begin
          got_ans = expected_answers.pop_front();
          if (res_if.status !== got_ans.status) begin
            report_mismatch("status", 32'(res_if.status), 32'(got_ans.status));
          end
          if (res_if.position !== got_ans.position) begin
            report_mismatch("position", res_if.position, got_ans.position);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        req_fire = 1'b1;
        accepted_count++;
        if (predict_answer(ssfm_pkg::func_e'(req_if.func), req_if.code, want)) begin
          expected_answers.push_back(want);
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_substring_first_match: errors");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.func  = ssfm_pkg::FUNC_START;
    req_if.code  = '0;
    res_if.ready = 1'b0;
    needle_len   = 0;
    window_fill  = 0;
    hay_count    = '0;
    answered     = 1'b0;
    needle_over  = 1'b0;
    for (int k = 0; k < ssfm_pkg::NEEDLE_MAX; k++) window[k] = '0;

    // Without a start after reset the block searches for an empty needle.
    queue_request(ssfm_pkg::FUNC_HAY,    21'h000000, 1'b0);
    queue_request(ssfm_pkg::FUNC_HAY,    21'h10FFFF, 1'b0);
    queue_request(ssfm_pkg::FUNC_END,    21'h000000, 1'b0);
    queue_request(ssfm_pkg::FUNC_START,  21'h10FFFF, 1'b0);
    queue_request(ssfm_pkg::FUNC_NEEDLE, 21'h10FFFF, 1'b0);
    queue_request(ssfm_pkg::FUNC_NEEDLE, 21'h000000, 1'b0);
    queue_request(ssfm_pkg::FUNC_HAY,    21'h10FFFF, 1'b0);
    queue_request(ssfm_pkg::FUNC_HAY,    21'h000000, 1'b0);
    queue_request(ssfm_pkg::FUNC_NEEDLE, 21'h000001, 1'b0);
    queue_request(ssfm_pkg::FUNC_END,    21'h000000, 1'b0);
    queue_request(ssfm_pkg::FUNC_START,  21'h000000, 1'b1);
    queue_request(ssfm_pkg::FUNC_END,    21'h10FFFF, 1'b0);
    // Needle longer than the haystack, with a late needle code in between.
    queue_request(ssfm_pkg::FUNC_START,  21'h000000, 1'b0);
    queue_request(ssfm_pkg::FUNC_NEEDLE, 21'h000005, 1'b0);
    queue_request(ssfm_pkg::FUNC_NEEDLE, 21'h000006, 1'b0);
    queue_request(ssfm_pkg::FUNC_HAY,    21'h000005, 1'b0);
    queue_request(ssfm_pkg::FUNC_NEEDLE, 21'h000007, 1'b0);
    queue_request(ssfm_pkg::FUNC_END,    21'h000000, 1'b0);
    queue_request(ssfm_pkg::FUNC_START,  21'h000000, 1'b0);
    queue_request(ssfm_pkg::FUNC_NEEDLE, 21'h000001, 1'b0);
    queue_request(ssfm_pkg::FUNC_HAY,    21'h000002, 1'b0);
    queue_request(ssfm_pkg::FUNC_HAY,    21'h000001, 1'b0);
    queue_request(ssfm_pkg::FUNC_START,  21'h000000, 1'b0);
    queue_request(ssfm_pkg::FUNC_NEEDLE, 21'h000003, 1'b0);
    queue_request(ssfm_pkg::FUNC_HAY,    21'h000004, 1'b0);
    queue_request(ssfm_pkg::FUNC_END,    21'h000000, 1'b0);

    while (total_items < RAND_ITEMS + 26) begin
      if ($urandom_range(0, 9) < 8) queue_search();
      else queue_noise();
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_count != total_items || expected_answers.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (expected_answers.size() != 0) begin
      report_mismatch("results never arrived, count", expected_answers.size(), 0);
    end

    if (mismatch_count == 0) begin
      $display("tb_substring_first_match: clean");
    end else begin
      $display("tb_substring_first_match: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/ssfm_pkg.sv
rtl/ssfm_in_if.sv
rtl/ssfm_out_if.sv
rtl/ssfm_cell.sv
rtl/substring_first_match.sv
tb/tb_substring_first_match.sv
